@@ rtl/dpd_pkg.sv @@
package dpd_pkg;

  localparam int unsigned MaxPayload = 512;
  localparam int unsigned CntW       = $clog2(MaxPayload + 1);
  localparam int unsigned LenW       = 10;
  localparam int unsigned LenMax     = (1 << LenW) - 1;

  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChIntr   = 8'h03;
  localparam logic [7:0] ChPlus   = 8'h2b;
  localparam logic [7:0] ChMinus  = 8'h2d;

  typedef enum logic [1:0] {
    PhIdle = 2'd0,
    PhData = 2'd1,
    PhCkHi = 2'd2,
    PhCkLo = 2'd3
  } phase_e;

  typedef enum logic [3:0] {
    EvNone  = 4'd0,
    EvData  = 4'd1,
    EvGood  = 4'd2,
    EvBad   = 4'd3,
    EvAck   = 4'd4,
    EvNack  = 4'd5,
    EvIntr  = 4'd6,
    EvOver  = 4'd7,
    EvAbort = 4'd8
  } event_e;

  typedef struct packed {
    event_e          ev;
    logic [7:0]      payload;
    logic [LenW-1:0] length;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } hex_t;

  function automatic hex_t hex_nibble(logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.nib = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.nib = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.nib = 4'(c[2:0] + 3'd1) + 4'd8;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

@@ rtl/dpd_core.sv @@
module dpd_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [7:0]        byte_i,
  output dpd_pkg::result_t  res_o
);

  dpd_pkg::phase_e            phase_q, phase_d;
  logic [7:0]                 sum_q, sum_d;
  logic [dpd_pkg::CntW-1:0]   count_q, count_d;
  dpd_pkg::hex_t              hex;
  logic [7:0]                 sum_lo;
  logic [31:0]                count_ext;

  always_comb begin
    hex       = dpd_pkg::hex_nibble(byte_i);
    sum_lo    = sum_q ^ {4'd0, hex.nib};
    count_ext = 32'(count_q);
    phase_d   = phase_q;
    sum_d     = sum_q;
    count_d   = count_q;
    res_o     = '{ev: dpd_pkg::EvNone, payload: 8'd0, length: '0};
    unique case (phase_q)
      dpd_pkg::PhIdle: begin
        if (byte_i == dpd_pkg::ChDollar) begin
          count_d = '0;
          sum_d   = 8'd0;
          phase_d = dpd_pkg::PhData;
        end else if (byte_i == dpd_pkg::ChPlus) begin
          res_o.ev = dpd_pkg::EvAck;
        end else if (byte_i == dpd_pkg::ChMinus) begin
          res_o.ev = dpd_pkg::EvNack;
        end else if (byte_i == dpd_pkg::ChIntr) begin
          res_o.ev = dpd_pkg::EvIntr;
        end
      end
      dpd_pkg::PhData: begin
        if (byte_i == dpd_pkg::ChHash) begin
          phase_d = dpd_pkg::PhCkHi;
        end else if (count_q >= dpd_pkg::CntW'(dpd_pkg::MaxPayload)) begin
          res_o.ev = dpd_pkg::EvOver;
        end else begin
          count_d       = count_q + 1'b1;
          sum_d         = sum_q + byte_i;
          res_o.ev      = dpd_pkg::EvData;
          res_o.payload = byte_i;
        end
      end
      dpd_pkg::PhCkHi: begin
        if (!hex.ok) begin
          phase_d  = dpd_pkg::PhIdle;
          res_o.ev = dpd_pkg::EvAbort;
        end else begin
          sum_d   = sum_q ^ {hex.nib, 4'd0};
          phase_d = dpd_pkg::PhCkLo;
        end
      end
      dpd_pkg::PhCkLo: begin
        phase_d = dpd_pkg::PhIdle;
        if (!hex.ok) begin
          res_o.ev = dpd_pkg::EvAbort;
        end else begin
          sum_d    = sum_lo;
          res_o.ev = (sum_lo == 8'd0) ? dpd_pkg::EvGood : dpd_pkg::EvBad;
          res_o.length = (count_ext > 32'(dpd_pkg::LenMax)) ?
                         dpd_pkg::LenW'(dpd_pkg::LenMax) : count_ext[dpd_pkg::LenW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dpd_pkg::PhIdle;
      sum_q   <= 8'd0;
      count_q <= '0;
    end else if (valid_i) begin
      phase_q <= phase_d;
      sum_q   <= sum_d;
      count_q <= count_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= dpd_pkg::CntW'(dpd_pkg::MaxPayload))
    else $error("payload count above limit");

  a_verdict_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && (res_o.ev == dpd_pkg::EvGood || res_o.ev == dpd_pkg::EvBad)
    |=> phase_q == dpd_pkg::PhIdle && $past(phase_q) == dpd_pkg::PhCkLo)
    else $error("verdict outside second checksum digit");

  a_abort_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && res_o.ev == dpd_pkg::EvAbort |=> phase_q == dpd_pkg::PhIdle)
    else $error("abort did not return to idle");

endmodule

@@ rtl/dpd_obuf.sv @@
module dpd_obuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  dpd_pkg::result_t  data_i,
  output logic              ready_o,
  output logic              valid_o,
  input  logic              pop_ready_i,
  output dpd_pkg::result_t  data_o
);

  logic             vld0_q, vld1_q;
  dpd_pkg::result_t slot0_q, slot1_q;
  logic             pop;

  assign pop     = vld0_q && pop_ready_i;
  assign ready_o = !vld1_q;
  assign valid_o = vld0_q;
  assign data_o  = slot0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
      vld1_q <= 1'b0;
    end else if (pop) begin
      vld0_q <= vld1_q || push_i;
      vld1_q <= vld1_q && push_i;
    end else if (push_i) begin
      vld0_q <= 1'b1;
      vld1_q <= vld0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (vld1_q) begin
        slot0_q <= slot1_q;
        if (push_i) begin
          slot1_q <= data_i;
        end
      end else if (push_i) begin
        slot0_q <= data_i;
      end
    end else if (push_i) begin
      if (vld0_q) begin
        slot1_q <= data_i;
      end else begin
        slot0_q <= data_i;
      end
    end
  end

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld1_q |-> vld0_q)
    else $error("skid slot holds data ahead of output slot");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !vld1_q)
    else $error("push into full buffer");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld0_q && !pop_ready_i |=> vld0_q && $stable(slot0_q))
    else $error("stalled result changed");

endmodule

@@ rtl/debug_packet_deframer.sv @@
// Debugger packet deframer: takes one link byte per transfer and recovers
// '$' payload '#' hh packets, giving exactly one result per byte (payload
// pass-through, good/bad verdict with length, ack/nack/interrupt, overlong
// drop, or abort on a non-hex checksum digit). Each byte is captured in an
// input register, decoded combinationally against the phase, sum and count
// registers, and pushed into a two-entry output buffer, so one byte is taken
// per clock while the result side keeps up; the result is valid once it has
// been written into the output buffer. The input side stalls only when both
// output buffer entries are full.
module debug_packet_deframer (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [7:0]               rx_byte_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [3:0]               event_res_o,
  output logic [7:0]               payload_byte_o,
  output logic [dpd_pkg::LenW-1:0] packet_length_o
);

  logic             in_vld_q;
  logic [7:0]       in_byte_q;
  logic             buf_ready;
  logic             adv;
  dpd_pkg::result_t res;
  dpd_pkg::result_t out_res;

  assign adv        = in_vld_q && buf_ready;
  assign in_ready_o = !in_vld_q || buf_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
  end

  dpd_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (adv),
    .byte_i  (in_byte_q),
    .res_o   (res)
  );

  dpd_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (adv),
    .data_i      (res),
    .ready_o     (buf_ready),
    .valid_o     (out_valid_o),
    .pop_ready_i (out_ready_i),
    .data_o      (out_res)
  );

  assign event_res_o     = out_res.ev;
  assign payload_byte_o  = out_res.payload;
  assign packet_length_o = out_res.length;

endmodule

@@ dv/tb_debug_packet_deframer.sv @@
`timescale 1ns / 1ps

module tb_debug_packet_deframer;
  import dpd_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  typedef enum int {
    FrGood,
    FrBad,
    FrAbortHi,
    FrAbortLo
  } frame_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [7:0]          rx_byte_i = 8'h00;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [3:0]          event_res_o;
  logic [7:0]          payload_byte_o;
  logic [LenW-1:0]     packet_length_o;

  logic [7:0]          tx_bytes[$];
  result_t             expected_events[$];
  int                  queued_n = 0;
  int                  send_idle_pct = 19;
  int                  recv_idle_pct = 61;
  int                  err_cnt = 0;

  // deframer state as seen by the predictor
  phase_e              link_phase = PhIdle;
  logic [7:0]          frame_sum = 8'h00;
  int unsigned         frame_cnt = 0;

  debug_packet_deframer u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .event_res_o    (event_res_o),
    .payload_byte_o (payload_byte_o),
    .packet_length_o(packet_length_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // {is_hex, nibble}
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
    if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h61 + 8'd10)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h41 + 8'd10)};
    return 5'b0;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
    if (nib < 4'd10) return 8'h30 + 8'(nib);
    return (upper ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
  endfunction

  function automatic logic [7:0] random_non_hex();
    logic [7:0] c;
    logic [4:0] hv;
    c  = 8'($urandom_range(255));
    hv = hex_value(c);
    while (hv[4]) begin
      c  = 8'($urandom_range(255));
      hv = hex_value(c);
    end
    return c;
  endfunction

  function automatic result_t deframe_step(input logic [7:0] c);
    result_t    r;
    logic [4:0] hv;
    r.ev      = EvNone;
    r.payload = 8'h00;
    r.length  = '0;
    hv        = hex_value(c);
    case (link_phase)
      PhIdle: begin
        if (c == ChDollar) begin
          frame_cnt  = 0;
          frame_sum  = 8'h00;
          link_phase = PhData;
        end else if (c == ChPlus) begin
          r.ev = EvAck;
        end else if (c == ChMinus) begin
          r.ev = EvNack;
        end else if (c == ChIntr) begin
          r.ev = EvIntr;
        end
      end
      PhData: begin
        if (c == ChHash) begin
          link_phase = PhCkHi;
        end else if (frame_cnt >= MaxPayload) begin
          r.ev = EvOver;
        end else begin
          frame_cnt++;
          frame_sum = frame_sum + c;
          r.ev      = EvData;
          r.payload = c;
        end
      end
      PhCkHi: begin
        if (!hv[4]) begin
          link_phase = PhIdle;
          r.ev       = EvAbort;
        end else begin
          frame_sum  = frame_sum ^ {hv[3:0], 4'h0};
          link_phase = PhCkLo;
        end
      end
      default: begin
        link_phase = PhIdle;
        if (!hv[4]) begin
          r.ev = EvAbort;
        end else begin
          frame_sum = frame_sum ^ {4'h0, hv[3:0]};
          r.ev      = (frame_sum == 8'h00) ? EvGood : EvBad;
          r.length  = (frame_cnt > LenMax) ? LenW'(LenMax) : LenW'(frame_cnt);
        end
      end
    endcase
    return r;
  endfunction

  task automatic push_byte(input logic [7:0] b);
    tx_bytes.push_back(b);
    queued_n++;
  endtask

  task automatic push_frame(input byte_q_t body, input frame_e kind);
    logic [7:0] ck;
    logic       upper;
    int         n;
    ck    = 8'h00;
    n     = 0;
    upper = 1'($urandom_range(1));
    push_byte(ChDollar);
    foreach (body[i]) begin
      push_byte(body[i]);
      if (n < MaxPayload) ck = ck + body[i];
      n++;
    end
    push_byte(ChHash);
    if (kind == FrBad) ck = ck ^ 8'($urandom_range(1, 255));
    if (kind == FrAbortHi) begin
      push_byte(random_non_hex());
    end else begin
      push_byte(hex_char(ck[7:4], upper));
      push_byte(kind == FrAbortLo ? random_non_hex() : hex_char(ck[3:0], upper));
    end
  endtask

  function automatic byte_q_t random_body(input int n);
    byte_q_t    body;
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(255));
      if (b == ChHash) b = ChDollar;
      body.push_back(b);
    end
    return body;
  endfunction

  task automatic push_random_traffic(input int target);
    int         r;
    logic [7:0] b;
    while (queued_n < target) begin
      r = $urandom_range(99);
      if (r < 10) begin
        b = 8'($urandom_range(255));
        push_byte(b == ChDollar ? ChPlus : b);
      end else if (r < 72) begin
        push_frame(random_body($urandom_range(0, 12)), FrGood);
      end else if (r < 84) begin
        push_frame(random_body($urandom_range(0, 12)), FrBad);
      end else if (r < 94) begin
        push_frame(random_body($urandom_range(0, 6)),
                   $urandom_range(1) ? FrAbortHi : FrAbortLo);
      end else begin
        case ($urandom_range(2))
          0:       push_byte(ChPlus);
          1:       push_byte(ChMinus);
          default: push_byte(ChIntr);
        endcase
      end
    end
  endtask

  task automatic drain_sender();
    while (tx_bytes.size() != 0) @(posedge clk_i);
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) expected_events.push_back(deframe_step(rx_byte_i));
      if (!in_valid_i || in_ready_o) begin
        if (tx_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          rx_byte_i  <= tx_bytes.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_r;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_events.size() == 0) begin
          $error("unexpected result: event_res %0d", event_res_o);
          err_cnt++;
        end else begin
          exp_r = expected_events.pop_front();
          if (event_res_o !== exp_r.ev) begin
            $error("event_res: expected %0d, got %0d", exp_r.ev, event_res_o);
            err_cnt++;
          end
          if (payload_byte_o !== exp_r.payload) begin
            $error("payload_byte: expected %0h, got %0h", exp_r.payload, payload_byte_o);
            err_cnt++;
          end
          if (packet_length_o !== exp_r.length) begin
            $error("packet_length: expected %0d, got %0d", exp_r.length, packet_length_o);
            err_cnt++;
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    byte_q_t body;

    // link control bytes and ignored bytes between frames
    push_byte(ChPlus);
    push_byte(ChMinus);
    push_byte(ChIntr);
    push_byte(8'h00);
    // extremes and a dollar inside the payload
    body = '{8'h00, 8'hff, ChDollar};
    push_frame(body, FrGood);
    body = {};
    push_frame(body, FrGood);
    body = '{8'h5a};
    push_frame(body, FrBad);
    body = {};
    push_frame(body, FrAbortHi);
    push_frame(body, FrAbortLo);
    push_random_traffic(35);

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    drain_sender();
    send_idle_pct = 61;
    recv_idle_pct = 19;
    // payload past the size limit
    push_frame(random_body(MaxPayload + $urandom_range(1, 4)), FrGood);
    push_random_traffic(queued_n + 10);

    drain_sender();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_random_traffic(queued_n + 10);

    drain_sender();
    while (in_valid_i || expected_events.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb_debug_packet_deframer: clean");
    end else begin
      $display("tb_debug_packet_deframer: errors");
    end
    $finish;
  end

  initial begin
    #(3_000_000);
    $display("tb_debug_packet_deframer: errors");
    $finish;
  end

endmodule

@@ files.f @@
rtl/dpd_pkg.sv
rtl/dpd_core.sv
rtl/dpd_obuf.sv
rtl/debug_packet_deframer.sv
dv/tb_debug_packet_deframer.sv
